// File: hdl/mrpc_pkg.sv
// Shared types, character codes and code matching helpers for the meter readout calculator.
package mrpc_pkg;

   localparam int NUM_CODES = 5;

   localparam logic [2:0] CODE_TIME = 3'd0;
   localparam logic [2:0] CODE_BATT = 3'd1;
   localparam logic [2:0] CODE_ACT  = 3'd2;
   localparam logic [2:0] CODE_IND  = 3'd3;
   localparam logic [2:0] CODE_CAP  = 3'd4;

   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam logic [7:0] CODE_TEXT [0:4][0:7] = '{
      '{"0", ".", "9", ".", "1", "(", 8'h00, 8'h00},
      '{"C", ".", "6", ".", "3", "(", 8'h00, 8'h00},
      '{"1", ".", "8", ".", "0", "(", 8'h00, 8'h00},
      '{"1", "3", "0", ".", "8", ".", "0", "("},
      '{"1", "3", "1", ".", "8", ".", "0", "("}
   };
   localparam logic [3:0] CODE_LEN [0:4] = '{4'd6, 4'd6, 4'd6, 4'd8, 4'd8};

   localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [30:0] SAT31         = 31'h7FFF_FFFF;

   // one decoded frame handed from the parser to the arithmetic side
   typedef struct packed {
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
      logic [9:0]  battery;
      logic [29:0] act;
      logic [29:0] ind;
      logic [29:0] cap;
      logic [2:0]  mask;
   } frame_type;

   typedef struct packed {
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
      logic [9:0]  battery_level;
      logic [31:0] active_energy_delta;
      logic [31:0] inductive_energy_delta;
      logic [31:0] capacitive_energy_delta;
      logic        reactive_is_inductive;
      logic [30:0] active_power;
      logic [30:0] reactive_power;
      logic [31:0] apparent_power;
      logic [6:0]  power_factor;
   } result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // next partial-match length for one code after byte c
   function automatic logic [3:0] advance(input int code, input logic [3:0] k_in,
                                          input logic [7:0] c);
      logic [3:0] k;
      logic [3:0] res;
      logic       ok;
      logic       found;
      int         idx;
      k     = (k_in >= CODE_LEN[code]) ? 4'd0 : k_in;
      res   = 4'd0;
      found = 1'b0;
      idx   = 0;
      for (int n = 8; n >= 1; n--) begin
         if (!found && (n <= int'(k) + 1)) begin
            ok = (CODE_TEXT[code][n-1] == c);
            for (int i = 0; i < 7; i++) begin
               if (i + 1 < n) begin
                  idx = int'(k) + 1 - n + i;
                  if (CODE_TEXT[code][i] != CODE_TEXT[code][idx[2:0]]) ok = 1'b0;
               end
            end
            if (ok) begin
               res   = 4'(n);
               found = 1'b1;
            end
         end
      end
      return res;
   endfunction

endpackage

// File: hdl/mrpc_div.sv
// Restoring divider, one quotient bit per cycle.
module mrpc_div
   import mrpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [43:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [43:0] quo
);

   logic [31:0] rem_ff, rem_in;
   logic [43:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [32:0] shifted;
   logic [32:0] diff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[43]};
      diff    = shifted - {1'b0, den_ff};
      if (start) begin
         quo_in = num;
         den_in = den;
         rem_in = '0;
         cnt_in = 6'd44;
      end else if (cnt_ff != 6'd0) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[42:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[42:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// File: hdl/mrpc_front.sv
// Telegram parser: code matching, value capture and decoding, frame end detection.
module mrpc_front
   import mrpc_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 1024,
   parameter int MAX_VALUE_CHARS = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   output logic       frame_push,
   output frame_type  frame
);

   localparam int CNT_W = $clog2(MAX_FRAME_BYTES);
   localparam int LEN_W = $clog2(MAX_VALUE_CHARS + 1);

   logic             phase_ff, phase_in;
   logic [2:0]       tag_ff [NUM_CODES];
   logic [2:0]       tag_in [NUM_CODES];
   logic [4:0]       seen_ff, seen_in;
   logic [2:0]       cap_ff, cap_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic             bad_ff, bad_in;
   logic [29:0]      acc_ff, acc_in;
   logic [7:0]       ch_ff [8];
   logic [7:0]       ch_in [8];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [6:0]       hour_ff, hour_in, min_ff, min_in, sec_ff, sec_in;
   logic [9:0]       batt_ff, batt_in;
   logic [29:0]      nen_ff [3];
   logic [29:0]      nen_in [3];
   logic [2:0]       nval_ff, nval_in;
   logic             done;
   logic             best_found;
   logic [2:0]       best;
   logic [3:0]       n;
   logic [1:0]       e;

   function automatic logic [6:0] two(input logic [7:0] a, input logic [7:0] b);
      return 7'(a[3:0]) * 7'd10 + 7'(b[3:0]);
   endfunction

   always_comb begin
      phase_in   = phase_ff;
      tag_in     = tag_ff;
      seen_in    = seen_ff;
      cap_in     = cap_ff;
      len_in     = len_ff;
      ovf_in     = ovf_ff;
      bad_in     = bad_ff;
      acc_in     = acc_ff;
      ch_in      = ch_ff;
      count_in   = count_ff;
      hour_in    = hour_ff;
      min_in     = min_ff;
      sec_in     = sec_ff;
      batt_in    = batt_ff;
      nen_in     = nen_ff;
      nval_in    = nval_ff;
      done       = 1'b0;
      best_found = 1'b0;
      best       = 3'd0;
      n          = 4'd0;
      e          = cap_ff[1:0] - 2'd2;
      frame      = '0;
      if (accept) begin
         count_in = count_ff + CNT_W'(1);
         done     = (rx_byte == CH_BANG) || (count_ff == CNT_W'(MAX_FRAME_BYTES - 1));
         if (rx_byte != CH_BANG) begin
            if (phase_ff) begin
               if (rx_byte == CH_RPAREN || rx_byte == CH_STAR) begin
                  case (cap_ff)
                     CODE_TIME: begin
                        if (len_ff >= LEN_W'(8) && is_digit(ch_ff[0]) && is_digit(ch_ff[1]) &&
                            is_digit(ch_ff[3]) && is_digit(ch_ff[4]) &&
                            is_digit(ch_ff[6]) && is_digit(ch_ff[7])) begin
                           hour_in = two(ch_ff[0], ch_ff[1]);
                           min_in  = two(ch_ff[3], ch_ff[4]);
                           sec_in  = two(ch_ff[6], ch_ff[7]);
                        end
                     end
                     CODE_BATT: begin
                        if (len_ff >= LEN_W'(4) && is_digit(ch_ff[0]) && is_digit(ch_ff[2]) &&
                            is_digit(ch_ff[3])) begin
                           batt_in = 10'(ch_ff[0][3:0]) * 10'd100 +
                                     10'(two(ch_ff[2], ch_ff[3]));
                        end
                     end
                     CODE_ACT, CODE_IND, CODE_CAP: begin
                        if (len_ff == LEN_W'(9) && !ovf_ff && !bad_ff) begin
                           nen_in[e]  = acc_ff;
                           nval_in[e] = 1'b1;
                        end
                     end
                     default: ;
                  endcase
                  phase_in = 1'b0;
                  for (int k = 0; k < NUM_CODES; k++) tag_in[k] = 3'd0;
               end else if (len_ff < LEN_W'(MAX_VALUE_CHARS)) begin
                  for (int i = 0; i < 8; i++) begin
                     if (len_ff == LEN_W'(i)) ch_in[i] = rx_byte;
                  end
                  len_in = len_ff + LEN_W'(1);
                  // running energy value, dots skipped
                  if (is_digit(rx_byte)) begin
                     acc_in = 30'(acc_ff * 30'd10) + 30'(rx_byte[3:0]);
                  end else if (rx_byte != CH_DOT) begin
                     bad_in = 1'b1;
                  end
               end else begin
                  ovf_in = 1'b1;
               end
            end else begin
               for (int k = 0; k < NUM_CODES; k++) begin
                  n = advance(k, {1'b0, tag_ff[k]}, rx_byte);
                  if (n == CODE_LEN[k]) begin
                     tag_in[k] = 3'd0;
                     if (!best_found || CODE_LEN[k] > CODE_LEN[best]) begin
                        best       = 3'(k);
                        best_found = 1'b1;
                     end
                  end else begin
                     tag_in[k] = n[2:0];
                  end
               end
               if (best_found && !seen_ff[best]) begin
                  seen_in[best] = 1'b1;
                  cap_in        = best;
                  phase_in      = 1'b1;
                  len_in        = '0;
                  ovf_in        = 1'b0;
                  bad_in        = 1'b0;
                  acc_in        = '0;
               end
            end
         end
         if (done) begin
            frame.hour    = hour_in;
            frame.minute  = min_in;
            frame.second  = sec_in;
            frame.battery = batt_in;
            frame.act     = nen_in[0];
            frame.ind     = nen_in[1];
            frame.cap     = nen_in[2];
            frame.mask    = nval_in;
            phase_in      = 1'b0;
            for (int k = 0; k < NUM_CODES; k++) tag_in[k] = 3'd0;
            seen_in  = '0;
            cap_in   = CODE_TIME;
            len_in   = '0;
            ovf_in   = 1'b0;
            count_in = '0;
            nval_in  = '0;
         end
      end
   end

   assign frame_push = done;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         for (int k = 0; k < NUM_CODES; k++) tag_ff[k] <= 3'd0;
         seen_ff  <= '0;
         cap_ff   <= CODE_TIME;
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
         bad_ff   <= 1'b0;
         acc_ff   <= '0;
         count_ff <= '0;
         hour_ff  <= '0;
         min_ff   <= '0;
         sec_ff   <= '0;
         batt_ff  <= '0;
         for (int i = 0; i < 3; i++) nen_ff[i] <= '0;
         nval_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         tag_ff   <= tag_in;
         seen_ff  <= seen_in;
         cap_ff   <= cap_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
         bad_ff   <= bad_in;
         acc_ff   <= acc_in;
         count_ff <= count_in;
         hour_ff  <= hour_in;
         min_ff   <= min_in;
         sec_ff   <= sec_in;
         batt_ff  <= batt_in;
         nen_ff   <= nen_in;
         nval_ff  <= nval_in;
      end
      ch_ff <= ch_in;
   end

endmodule

// File: hdl/mrpc_queue.sv
// Two-entry frame queue between parser and arithmetic side.
module mrpc_queue
   import mrpc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  frame_type wr_data,
   input  logic      pop,
   output frame_type rd_data,
   output logic      full,
   output logic      empty
);

   frame_type  slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? !wr_ff : wr_ff;
      rd_in  = do_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) slot_ff[wr_ff] <= wr_data;
   end

endmodule

// File: hdl/mrpc_back.sv
// Frame arithmetic: energy deltas, elapsed time, powers, square root and power factor.
module mrpc_back
   import mrpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  frame_type  q_data,
   output logic       q_pop,
   output logic       res_valid,
   input  logic       res_ready,
   output result_type result
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_NOW  = 4'd1;
   localparam logic [3:0] ST_DIFF = 4'd2;
   localparam logic [3:0] ST_MULA = 4'd3;
   localparam logic [3:0] ST_DIVA = 4'd4;
   localparam logic [3:0] ST_MULR = 4'd5;
   localparam logic [3:0] ST_DIVR = 4'd6;
   localparam logic [3:0] ST_SQA  = 4'd7;
   localparam logic [3:0] ST_SQR  = 4'd8;
   localparam logic [3:0] ST_SUM  = 4'd9;
   localparam logic [3:0] ST_SQRT = 4'd10;
   localparam logic [3:0] ST_PF   = 4'd11;
   localparam logic [3:0] ST_DIVP = 4'd12;
   localparam logic [3:0] ST_OUT  = 4'd13;

   logic [3:0]  state_ff;
   frame_type   rec_ff;
   logic [31:0] old_e_ff [3];
   logic [31:0] delta_ff [3];
   logic        mark_ff;
   logic [18:0] old_ts_ff, now_ff;
   logic [31:0] diff_ff, diff_in;
   logic [30:0] pa_ff, pr_ff;
   logic [31:0] app_ff;
   logic [6:0]  pf_ff;
   logic [61:0] sqa_ff, sqr_ff;
   logic [63:0] rem_ff, res_ff, bit_ff;
   logic [63:0] trial, res_next;
   logic        div_start, div_done;
   logic [43:0] div_num, div_quo;
   logic [31:0] div_den;
   logic [30:0] div_sat;
   logic [29:0] new_e [3];

   mrpc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign div_sat = (div_quo > 44'(SAT31)) ? SAT31 : div_quo[30:0];
   assign new_e   = '{rec_ff.act, rec_ff.ind, rec_ff.cap};

   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = diff_ff;
      case (state_ff)
         ST_MULA: begin
            div_start = 1'b1;
            div_num   = 44'(delta_ff[0]) * 44'(SECS_PER_HOUR);
         end
         ST_MULR: begin
            div_start = 1'b1;
            div_num   = 44'(mark_ff ? delta_ff[1] : delta_ff[2]) * 44'(SECS_PER_HOUR);
         end
         ST_PF: begin
            div_start = (app_ff != 32'd0);
            div_num   = 44'(pa_ff) * 44'd100;
            div_den   = app_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      if ({13'd0, now_ff} < {13'd0, old_ts_ff}) begin
         diff_in = {13'd0, now_ff} + SECS_PER_DAY - {13'd0, old_ts_ff};
      end else begin
         diff_in = {13'd0, now_ff} - {13'd0, old_ts_ff};
      end
      trial    = res_ff + bit_ff;
      res_next = (rem_ff >= trial) ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);
   end

   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign res_valid = (state_ff == ST_OUT);

   always_comb begin
      result.hour                    = rec_ff.hour;
      result.minute                  = rec_ff.minute;
      result.second                  = rec_ff.second;
      result.battery_level           = rec_ff.battery;
      result.active_energy_delta     = delta_ff[0];
      result.inductive_energy_delta  = delta_ff[1];
      result.capacitive_energy_delta = delta_ff[2];
      result.reactive_is_inductive   = mark_ff;
      result.active_power            = pa_ff;
      result.reactive_power          = pr_ff;
      result.apparent_power          = app_ff;
      result.power_factor            = pf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         for (int i = 0; i < 3; i++) begin
            old_e_ff[i] <= '0;
            delta_ff[i] <= '0;
         end
         mark_ff   <= 1'b0;
         old_ts_ff <= '0;
         pa_ff     <= '0;
         pr_ff     <= '0;
         app_ff    <= '0;
         pf_ff     <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  rec_ff   <= q_data;
                  state_ff <= ST_NOW;
               end
            end
            ST_NOW: begin
               now_ff <= 19'(rec_ff.hour) * 19'd3600 + 19'(rec_ff.minute) * 19'd60 +
                         19'(rec_ff.second);
               for (int i = 0; i < 3; i++) begin
                  if (rec_ff.mask[i]) begin
                     delta_ff[i] <= {2'b00, new_e[i]} - old_e_ff[i];
                     old_e_ff[i] <= {2'b00, new_e[i]};
                  end
               end
               // inductive has priority over capacitive when both arrive
               if (rec_ff.mask[1]) mark_ff <= 1'b1;
               else if (rec_ff.mask[2]) mark_ff <= 1'b0;
               state_ff <= ST_DIFF;
            end
            ST_DIFF: begin
               diff_ff   <= diff_in;
               old_ts_ff <= now_ff;
               state_ff  <= (diff_in == 32'd0) ? ST_OUT : ST_MULA;
            end
            ST_MULA: state_ff <= ST_DIVA;
            ST_DIVA: begin
               if (div_done) begin
                  pa_ff    <= div_sat;
                  state_ff <= ST_MULR;
               end
            end
            ST_MULR: state_ff <= ST_DIVR;
            ST_DIVR: begin
               if (div_done) begin
                  pr_ff    <= div_sat;
                  state_ff <= ST_SQA;
               end
            end
            ST_SQA: begin
               sqa_ff   <= 62'(pa_ff) * 62'(pa_ff);
               state_ff <= ST_SQR;
            end
            ST_SQR: begin
               sqr_ff   <= 62'(pr_ff) * 62'(pr_ff);
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               rem_ff   <= 64'(sqa_ff) + 64'(sqr_ff);
               res_ff   <= '0;
               bit_ff   <= 64'd1 << 62;
               state_ff <= ST_SQRT;
            end
            ST_SQRT: begin
               if (rem_ff >= trial) rem_ff <= rem_ff - trial;
               res_ff <= res_next;
               bit_ff <= bit_ff >> 2;
               if (bit_ff[0]) begin
                  app_ff   <= res_next[31:0];
                  state_ff <= ST_PF;
               end
            end
            ST_PF: begin
               if (app_ff == 32'd0) begin
                  pf_ff    <= 7'd0;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_DIVP;
               end
            end
            ST_DIVP: begin
               if (div_done) begin
                  pf_ff    <= div_quo[6:0];
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (res_ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// File: hdl/meter_readout_power_calculator.sv
// Top level of the meter readout power calculator: parser, frame queue, arithmetic, result register.
//
// Usage:
//  - Input channel: one telegram byte per transfer on req_rx_byte, taken when req_push is
//    high and req_full is low. The parser takes one byte per cycle while req_full is low.
//  - A frame ends on '!' or on the MAX_FRAME_BYTES-th byte; each frame end yields exactly
//    one result, all other bytes yield none.
//  - Result channel: while rsp_empty is low the rsp_ ports hold the oldest result;
//    it is transferred when rsp_pop is high.
//  - Processing: when no time has elapsed the result goes out directly, else it passes
//    through two or three 44-step divisions in the shared divider (the third only for
//    nonzero apparent power), a 32-step square root and the setup states around them.
//  - Throughput: one byte per cycle within a frame while req_full is low; frames are
//    processed one at a time by the arithmetic side, so frame ends arriving faster than it
//    finishes them fill the two-entry frame queue, and req_full is raised until space frees.
//  - When the receiver stalls, the finished result waits in the output register, the
//    arithmetic side holds its next result, and the queue then backs up into req_full.
//  - Reset clears the parser, the stored time, battery, energies and powers; no clearing
//    pass is needed.
module meter_readout_power_calculator
   import mrpc_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 1024,
   parameter int MAX_VALUE_CHARS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [6:0]  rsp_hour,
   output logic [6:0]  rsp_minute,
   output logic [6:0]  rsp_second,
   output logic [9:0]  rsp_battery_level,
   output logic [31:0] rsp_active_energy_delta,
   output logic [31:0] rsp_inductive_energy_delta,
   output logic [31:0] rsp_capacitive_energy_delta,
   output logic        rsp_reactive_is_inductive,
   output logic [30:0] rsp_active_power,
   output logic [30:0] rsp_reactive_power,
   output logic [31:0] rsp_apparent_power,
   output logic [6:0]  rsp_power_factor
);

   logic       byte_xfer;
   logic       frame_push;
   frame_type  frame_wr, frame_rd;
   logic       q_full, q_empty, q_pop;
   logic       res_valid, res_ready;
   result_type result;
   result_type out_ff;
   logic       out_valid_ff, out_valid_in;

   // parser stalls whole while the queue cannot take a frame end
   assign req_full  = q_full;
   assign byte_xfer = req_push && !q_full;

   mrpc_front #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
      .MAX_VALUE_CHARS (MAX_VALUE_CHARS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (byte_xfer),
      .rx_byte    (req_rx_byte),
      .frame_push (frame_push),
      .frame      (frame_wr)
   );

   mrpc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (frame_push),
      .wr_data (frame_wr),
      .pop     (q_pop),
      .rd_data (frame_rd),
      .full    (q_full),
      .empty   (q_empty)
   );

   mrpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (frame_rd),
      .q_pop     (q_pop),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .result    (result)
   );

   // output register: loads when empty or being drained this cycle
   assign res_ready    = !out_valid_ff || rsp_pop;
   assign out_valid_in = (res_valid && res_ready) || (out_valid_ff && !rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (res_valid && res_ready) out_ff <= result;
   end

   assign rsp_empty                   = !out_valid_ff;
   assign rsp_hour                    = out_ff.hour;
   assign rsp_minute                  = out_ff.minute;
   assign rsp_second                  = out_ff.second;
   assign rsp_battery_level           = out_ff.battery_level;
   assign rsp_active_energy_delta     = out_ff.active_energy_delta;
   assign rsp_inductive_energy_delta  = out_ff.inductive_energy_delta;
   assign rsp_capacitive_energy_delta = out_ff.capacitive_energy_delta;
   assign rsp_reactive_is_inductive   = out_ff.reactive_is_inductive;
   assign rsp_active_power            = out_ff.active_power;
   assign rsp_reactive_power          = out_ff.reactive_power;
   assign rsp_apparent_power          = out_ff.apparent_power;
   assign rsp_power_factor            = out_ff.power_factor;

   // a frame end is never offered to a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      frame_push |-> !q_full)
      else $error("frame pushed into full queue");

   // power factor never exceeds 100
   a_pf_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_power_factor <= 7'd100))
      else $error("power factor out of range");

   // zero apparent power always comes with zero factor
   a_pf_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_apparent_power == 32'd0) |-> (rsp_power_factor == 7'd0))
      else $error("nonzero factor with zero apparent power");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the meter readout power calculator.
`timescale 1ns / 100ps

module tb_top;
   import mrpc_pkg::*;

   localparam int FRAME_LIMIT = 1024;   // byte count that forces a frame end
   localparam int VALUE_MAX   = 10;     // value characters kept per capture
   localparam int DRAIN_WAIT  = 400;    // cycles after the last result, > divider latency
   localparam int HOLD_CYCLES = 600;    // long receiver stall to back the block up

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_rx_byte;
   logic        rsp_empty;
   logic        rsp_pop;
   result_type  rsp;

   meter_readout_power_calculator #(
      .MAX_FRAME_BYTES(FRAME_LIMIT),
      .MAX_VALUE_CHARS(VALUE_MAX)
   ) DUT (
      .clock                      (clock),
      .reset                      (reset),
      .req_push                   (req_push),
      .req_full                   (req_full),
      .req_rx_byte                (req_rx_byte),
      .rsp_empty                  (rsp_empty),
      .rsp_pop                    (rsp_pop),
      .rsp_hour                   (rsp.hour),
      .rsp_minute                 (rsp.minute),
      .rsp_second                 (rsp.second),
      .rsp_battery_level          (rsp.battery_level),
      .rsp_active_energy_delta    (rsp.active_energy_delta),
      .rsp_inductive_energy_delta (rsp.inductive_energy_delta),
      .rsp_capacitive_energy_delta(rsp.capacitive_energy_delta),
      .rsp_reactive_is_inductive  (rsp.reactive_is_inductive),
      .rsp_active_power           (rsp.active_power),
      .rsp_reactive_power         (rsp.reactive_power),
      .rsp_apparent_power         (rsp.apparent_power),
      .rsp_power_factor           (rsp.power_factor)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Telegram parser and power predictor
   // ---------------------------------------------------------------------
   string       tag_text [0:4] = '{"0.9.1(", "C.6.3(", "1.8.0(", "130.8.0(", "131.8.0("};

   bit          in_value;            // capturing a value vs. searching for a code
   logic [3:0]  match_len [0:4];
   logic [4:0]  seen_mask;
   logic [2:0]  cur_code;
   logic [7:0]  chars [0:VALUE_MAX-1];
   int          char_cnt;
   bit          chars_overflow;
   int          frame_bytes;
   logic [6:0]  tod_h, tod_m, tod_s;
   logic [9:0]  batt;
   logic [29:0] fresh_energy [0:2];  // 0 active, 1 inductive, 2 capacitive
   logic [2:0]  fresh_mask;
   logic [31:0] last_energy [0:2];
   logic [31:0] delta [0:2];
   bit          use_ind;
   logic [31:0] last_stamp;
   logic [31:0] pwr [0:3];

   result_type  readings_due [$];    // results still owed by the block
   int          fails;

   function automatic logic [3:0] next_match(int code, logic [3:0] k_in, logic [7:0] c);
      string      s;
      int         k;
      bit         ok;
      s = tag_text[code];
      k = (k_in >= s.len()) ? 0 : int'(k_in);
      for (int n = k + 1; n > 0; n--) begin
         ok = (s[n-1] == c);
         for (int i = 0; i + 1 < n; i++)
            if (s[i] != s[k + 1 - n + i]) ok = 0;
         if (ok) return 4'(n);
      end
      return 4'd0;
   endfunction

   function automatic bit digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic [6:0] pair(int at);
      return 7'((chars[at] - CH_ZERO) * 10 + (chars[at+1] - CH_ZERO));
   endfunction

   function automatic logic [31:0] root64(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] t;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (t * t <= x) r = t;
      end
      return r[31:0];
   endfunction

   function automatic logic [31:0] rate_of(logic [31:0] e, logic [31:0] secs);
      logic [63:0] p;
      p = 64'(e) * 64'd3600 / 64'(secs);
      return (p > 64'(SAT31)) ? 32'(SAT31) : p[31:0];
   endfunction

   task automatic close_value();
      logic [31:0] v;
      bit          ok;
      v = 0;
      if (cur_code == CODE_TIME) begin
         if (char_cnt >= 8 && digit(chars[0]) && digit(chars[1]) && digit(chars[3]) &&
             digit(chars[4]) && digit(chars[6]) && digit(chars[7])) begin
            tod_h = pair(0);
            tod_m = pair(3);
            tod_s = pair(6);
         end
      end else if (cur_code == CODE_BATT) begin
         if (char_cnt >= 4 && digit(chars[0]) && digit(chars[2]) && digit(chars[3]))
            batt = 10'((chars[0] - CH_ZERO) * 100 + pair(2));
      end else begin
         ok = (char_cnt == 9) && !chars_overflow;
         for (int i = 0; ok && i < 9; i++) begin
            if (chars[i] == CH_DOT) continue;
            if (!digit(chars[i])) ok = 0;
            else v = v * 10 + (chars[i] - CH_ZERO);
         end
         if (ok) begin
            fresh_energy[cur_code - CODE_ACT] = v[29:0];
            fresh_mask[cur_code - CODE_ACT] = 1'b1;
         end
      end
   endtask

   task automatic new_frame();
      in_value = 0;
      foreach (match_len[i]) match_len[i] = 0;
      seen_mask = 0;
      cur_code = CODE_TIME;
      char_cnt = 0;
      chars_overflow = 0;
      frame_bytes = 0;
      fresh_mask = 0;
   endtask

   task automatic close_frame(output result_type r);
      logic [31:0] now, diff, a, q, app;
      int          e;
      int          order [0:2];
      order = '{0, 2, 1};   // capacitive goes before inductive
      now = tod_h * 3600 + tod_m * 60 + tod_s;
      diff = (now < last_stamp) ? now + SECS_PER_DAY - last_stamp : now - last_stamp;
      last_stamp = now;
      for (int i = 0; i < 3; i++) begin
         e = order[i];
         if (fresh_mask[e]) begin
            delta[e] = 32'(fresh_energy[e]) - last_energy[e];
            last_energy[e] = 32'(fresh_energy[e]);
            if (e == 1) use_ind = 1;
            if (e == 2) use_ind = 0;
         end
      end
      if (diff != 0) begin
         a = rate_of(delta[0], diff);
         q = rate_of(use_ind ? delta[1] : delta[2], diff);
         app = root64(64'(a) * 64'(a) + 64'(q) * 64'(q));
         pwr[0] = a;
         pwr[1] = q;
         pwr[2] = app;
         pwr[3] = app ? 32'(64'(a) * 100 / 64'(app)) : 0;
      end
      r.hour = tod_h;
      r.minute = tod_m;
      r.second = tod_s;
      r.battery_level = batt;
      r.active_energy_delta = delta[0];
      r.inductive_energy_delta = delta[1];
      r.capacitive_energy_delta = delta[2];
      r.reactive_is_inductive = use_ind;
      r.active_power = pwr[0][30:0];
      r.reactive_power = pwr[1][30:0];
      r.apparent_power = pwr[2];
      r.power_factor = pwr[3][6:0];
   endtask

   // one accepted byte; got is set when the byte closes a frame
   task automatic parse_byte(input logic [7:0] c, output bit got, output result_type r);
      int best;
      int n;
      frame_bytes++;
      got = (c == CH_BANG) || (frame_bytes >= FRAME_LIMIT);
      r = '0;
      if (c != CH_BANG) begin
         if (in_value) begin
            if (c == CH_RPAREN || c == CH_STAR) begin
               close_value();
               in_value = 0;
               foreach (match_len[i]) match_len[i] = 0;
            end else if (char_cnt < VALUE_MAX) begin
               chars[char_cnt] = c;
               char_cnt++;
            end else begin
               chars_overflow = 1;
            end
         end else begin
            best = -1;
            for (int k = 0; k < NUM_CODES; k++) begin
               n = next_match(k, match_len[k], c);
               if (n == tag_text[k].len()) begin
                  match_len[k] = 0;
                  if (best < 0 || tag_text[k].len() > tag_text[best].len()) best = k;
               end else begin
                  match_len[k] = 4'(n);
               end
            end
            if (best >= 0 && !seen_mask[best]) begin
               seen_mask[best] = 1'b1;
               cur_code = 3'(best);
               in_value = 1;
               char_cnt = 0;
               chars_overflow = 0;
            end
         end
      end
      if (got) begin
         close_frame(r);
         new_frame();
      end
   endtask

   // ---------------------------------------------------------------------
   // Result checking: each popped result against the oldest owed one
   // ---------------------------------------------------------------------
   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      result_type w;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (readings_due.size() == 0) begin
            $error("result transfer with nothing owed");
            fails++;
         end else begin
            w = readings_due.pop_front();
            check_field("hour", w.hour, rsp.hour);
            check_field("minute", w.minute, rsp.minute);
            check_field("second", w.second, rsp.second);
            check_field("battery_level", w.battery_level, rsp.battery_level);
            check_field("active_energy_delta", w.active_energy_delta,
                        rsp.active_energy_delta);
            check_field("inductive_energy_delta", w.inductive_energy_delta,
                        rsp.inductive_energy_delta);
            check_field("capacitive_energy_delta", w.capacitive_energy_delta,
                        rsp.capacitive_energy_delta);
            check_field("reactive_is_inductive", w.reactive_is_inductive,
                        rsp.reactive_is_inductive);
            check_field("active_power", w.active_power, rsp.active_power);
            check_field("reactive_power", w.reactive_power, rsp.reactive_power);
            check_field("apparent_power", w.apparent_power, rsp.apparent_power);
            check_field("power_factor", w.power_factor, rsp.power_factor);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random pop bursts, one long hold on request, none when quiet
   // ---------------------------------------------------------------------
   bit quiet;      // last part of the run: no idling on either side
   bit hold_go;    // sender asks for the long receiver stall

   initial begin
      int n;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go) begin
            hold_go = 0;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_pop <= 1'b0;
            n = $urandom_range(1, 17);
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------
   typedef struct {
      logic [7:0] b;
      bit         typed;   // expectation written out by hand
      result_type r;
   } stim_row;

   stim_row     directed [$];
   logic [7:0]  telegram [$];
   int          sim_secs;
   logic [31:0] meter_kwh [0:2];

   // transfer one byte, with an optional random gap before it
   task automatic send_byte(input logic [7:0] b, output bit got, output result_type r);
      int n;
      if (!quiet && $urandom_range(0, 9) == 0) begin
         @(negedge clock);
         req_push <= 1'b0;
         n = $urandom_range(0, 16);
         repeat (n) @(negedge clock);
      end
      @(negedge clock);
      req_push <= 1'b1;
      req_rx_byte <= b;
      forever begin
         @(posedge clock);
         if (!req_full) break;
      end
      parse_byte(b, got, r);
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) telegram.push_back(s[i]);
   endtask

   task automatic send_telegram();
      bit         got;
      result_type r;
      while (telegram.size() > 0) begin
         send_byte(telegram.pop_front(), got, r);
         if (got) readings_due.push_back(r);
      end
   endtask

   // value text, sometimes damaged: wrong byte, extra length, cut short
   function automatic string damage(string s);
      string t;
      int    p;
      t = s;
      case ($urandom_range(0, 11))
         0: begin
            p = $urandom_range(0, t.len() - 1);
            t[p] = 8'($urandom_range(1, 255));
            if (t[p] == CH_RPAREN || t[p] == CH_STAR || t[p] == CH_BANG) t[p] = "x";
         end
         1: t = {t, "12"};
         2: t = t.substr(0, t.len() - 2);
         default: ;
      endcase
      return t;
   endfunction

   task automatic add_field(int code, string val);
      add_text({tag_text[code], damage(val)});
      add_text(($urandom_range(0, 3) == 0) ? "*kWh)" : ")");
      add_text("\r\n");
   endtask

   task automatic build_frame();
      int    order [0:4];
      int    t, j, hh;
      string v;
      telegram.delete();
      add_text("/XYZ5METER\r\n\x02");
      order = '{0, 1, 2, 3, 4};
      for (int i = 4; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      // meter clock moves on; sometimes it stands still or wraps midnight
      sim_secs = (sim_secs + $urandom_range(0, 3) * $urandom_range(0, 900)) % 86400;
      for (int i = 0; i < 5; i++) begin
         if ($urandom_range(0, 7) == 0) continue;   // quantity missing
         case (order[i])
            CODE_TIME: begin
               hh = ($urandom_range(0, 15) == 0) ? 99 : sim_secs / 3600;
               v = $sformatf("%02d:%02d:%02d", hh, (sim_secs / 60) % 60, sim_secs % 60);
            end
            CODE_BATT: v = $sformatf("%0d.%02d", $urandom_range(0, 9), $urandom_range(0, 99));
            default: begin
               j = order[i] - CODE_ACT;
               meter_kwh[j] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99999999)
                              : (meter_kwh[j] + $urandom_range(0, 5000)) % 100000000;
               v = $sformatf("%05d.%03d", meter_kwh[j] / 1000, meter_kwh[j] % 1000);
            end
         endcase
         add_field(order[i], v);
         if ($urandom_range(0, 5) == 0) add_text("0.0.0(4711)\r\n1.8.(junk)13");
         if ($urandom_range(0, 9) == 0) add_field(order[i], v);   // repeated code
      end
      if ($urandom_range(0, 9) == 0) add_text("1.8.0(0001");   // left open at the end
      repeat ($urandom_range(0, 3)) telegram.push_back(8'($urandom_range(0, 255)));
      add_text("!\r\n");
   endtask

   initial begin
      bit         got;
      result_type r;
      result_type z;
      string      s;
      fails = 0;
      quiet = 0;
      hold_go = 0;
      sim_secs = 0;
      meter_kwh = '{0, 0, 0};
      foreach (chars[i]) chars[i] = 0;
      tod_h = 0; tod_m = 0; tod_s = 0;
      batt = 0;
      fresh_energy = '{0, 0, 0};
      last_energy = '{0, 0, 0};
      delta = '{0, 0, 0};
      use_ind = 0;
      last_stamp = 0;
      pwr = '{0, 0, 0, 0};
      new_frame();

      reset = 1'b1;
      req_push = 1'b0;
      req_rx_byte = 8'h00;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: an empty frame right after reset reads all zero, byte
      // extremes, then a battery-only frame (no elapsed time, powers stay zero)
      z = '0;
      directed.push_back('{CH_BANG, 1, z});
      directed.push_back('{8'hFF, 0, z});
      directed.push_back('{8'h00, 0, z});
      s = "C.6.3(9.99)";
      for (int i = 0; i < s.len(); i++) directed.push_back('{s[i], 0, z});
      z.battery_level = 10'd999;
      directed.push_back('{CH_BANG, 1, z});
      // the longer code wins over the active-energy suffix, then a star ending
      s = "131.8.0(00012.345*";
      for (int i = 0; i < s.len(); i++) directed.push_back('{s[i], 0, z});
      directed.push_back('{CH_BANG, 0, z});

      foreach (directed[i]) begin
         send_byte(directed[i].b, got, r);
         if (got) readings_due.push_back(directed[i].typed ? directed[i].r : r);
      end

      // random telegrams
      for (int f = 0; f < 7; f++) begin
         quiet = (f >= 6);
         if (f == 1) begin
            // receiver stalls long while frame ends keep arriving
            hold_go = 1;
            repeat (40) begin
               send_byte(CH_BANG, got, r);
               if (got) readings_due.push_back(r);
            end
         end
         if (f == 3) begin
            // let the block drain completely before going on
            @(negedge clock);
            req_push <= 1'b0;
            wait (readings_due.size() == 0);
         end
         build_frame();
         send_telegram();
      end
      @(negedge clock);
      req_push <= 1'b0;

      wait (readings_due.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fails == 0)
         $display("PASS meter_readout_power_calculator");
      else
         $display("FAIL meter_readout_power_calculator");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("FAIL meter_readout_power_calculator");
      $finish;
   end

endmodule

// File: files.f
hdl/mrpc_pkg.sv
hdl/mrpc_div.sv
hdl/mrpc_front.sv
hdl/mrpc_queue.sv
hdl/mrpc_back.sv
hdl/meter_readout_power_calculator.sv
tb/tb_top.sv
